// ----- rtl/core/tlrq_pkg.sv -----
`default_nettype none

package tlrq_pkg;

    localparam int MAX_PROCESSES = 32;
    localparam int QUEUE_DEPTH   = 16;
    localparam int MESSAGE_LIMIT = 64;

    localparam int PID_W  = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
    localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [8:0] PID_LIMIT = 9'(MAX_PROCESSES);
    localparam logic [7:0] LEN_LIMIT = 8'(MESSAGE_LIMIT);

    localparam logic [2:0] CMD_SCHEDULE = 3'd0;
    localparam logic [2:0] CMD_WAKE     = 3'd1;
    localparam logic [2:0] CMD_DORMANT  = 3'd2;
    localparam logic [2:0] CMD_STOP     = 3'd3;
    localparam logic [2:0] CMD_ZOMBIE   = 3'd4;
    localparam logic [2:0] CMD_SEND     = 3'd5;

    localparam logic [2:0] ST_OK           = 3'd0;
    localparam logic [2:0] ST_EMPTY_ROOT   = 3'd1;
    localparam logic [2:0] ST_INVALID_ROOT = 3'd2;
    localparam logic [2:0] ST_FULL_DROP    = 3'd3;
    localparam logic [2:0] ST_BOX_BUSY     = 3'd4;
    localparam logic [2:0] ST_TOO_LONG     = 3'd5;
    localparam logic [2:0] ST_BAD_ID       = 3'd6;

    localparam logic [0:0] REG_ROOT_ID = 1'b0;

    typedef struct packed {
        logic [1:0] state;
        logic [7:0] sender;
        logic [6:0] length;
    } t_tab_entry;

    typedef struct packed {
        logic             en;
        logic             set_busy;
        logic [PID_W-1:0] idx;
        t_tab_entry       entry;
    } t_tab_wr;

    typedef struct packed {
        logic       push;
        logic       pop;
        logic [7:0] id;
    } t_fifo_ctl;

    typedef struct packed {
        logic empty;
        logic full;
    } t_fifo_sts;

endpackage

`default_nettype wire

// ----- rtl/core/tlrq_fifo.sv -----
`default_nettype none

module tlrq_fifo (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_rd_req,
    input  wire tlrq_pkg::t_fifo_ctl  i_ctl,
    output logic [7:0]                o_head_id,
    output tlrq_pkg::t_fifo_sts       o_sts
);

    logic [7:0]                    r_mem [tlrq_pkg::QUEUE_DEPTH];
    logic [7:0]                    r_rd_data;
    logic [tlrq_pkg::QPTR_W-1:0]   r_head, n_head;
    logic [tlrq_pkg::QPTR_W-1:0]   r_tail, n_tail;
    logic [tlrq_pkg::QCNT_W-1:0]   r_count, n_count;
    logic                          push_ok;
    logic                          pop_ok;

    localparam logic [tlrq_pkg::QPTR_W-1:0] LAST_SLOT =
        tlrq_pkg::QPTR_W'(tlrq_pkg::QUEUE_DEPTH - 1);

    assign o_sts.empty = (r_count == '0);
    assign o_sts.full  = (r_count == tlrq_pkg::QCNT_W'(tlrq_pkg::QUEUE_DEPTH));
    assign push_ok     = i_ctl.push && !o_sts.full;
    assign pop_ok      = i_ctl.pop && !o_sts.empty;
    assign o_head_id   = r_rd_data;

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (pop_ok) begin
            n_head = (r_head == LAST_SLOT) ? '0 : r_head + 1'b1;
        end
        if (push_ok) begin
            n_tail = (r_tail == LAST_SLOT) ? '0 : r_tail + 1'b1;
        end
        if (push_ok && !pop_ok) begin
            n_count = r_count + 1'b1;
        end else if (pop_ok && !push_ok) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_tail] <= i_ctl.id;
        end
        if (i_rd_req) begin
            r_rd_data <= r_mem[r_head];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/tlrq_ptab.sv -----
`default_nettype none

module tlrq_ptab (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_rd_req,
    input  wire logic [tlrq_pkg::PID_W-1:0] i_rd_idx,
    input  wire tlrq_pkg::t_tab_wr         i_wr,
    output tlrq_pkg::t_tab_entry           o_rd_entry,
    output logic                           o_rd_box_busy
);

    tlrq_pkg::t_tab_entry r_mem [tlrq_pkg::MAX_PROCESSES];
    tlrq_pkg::t_tab_entry r_rd_data;
    logic [tlrq_pkg::MAX_PROCESSES-1:0] r_written;
    logic [tlrq_pkg::MAX_PROCESSES-1:0] r_box_busy;
    logic r_rd_written;
    logic r_rd_busy;

    assign o_rd_entry    = r_rd_written ? r_rd_data : '0;
    assign o_rd_box_busy = r_rd_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written  <= '0;
            r_box_busy <= '0;
        end else begin
            if (i_wr.en) begin
                r_written[i_wr.idx] <= 1'b1;
            end
            if (i_wr.set_busy) begin
                r_box_busy[i_wr.idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.idx] <= i_wr.entry;
        end
        if (i_rd_req) begin
            r_rd_data    <= r_mem[i_rd_idx];
            r_rd_written <= r_written[i_rd_idx];
            r_rd_busy    <= r_box_busy[i_rd_idx];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/two_level_ready_queue_scheduler.sv -----
// The accepting edge sets r_busy, and the result word is then strobed on o_done from r_done, which registers r_busy.
// A command is not accepted while busy is high; on the accepting edge both FIFO heads and the process
// table entry are read, and busy covers the modify and write-back that follow.
// The receiver cannot stall: o_done lasts exactly one cycle.
// Reset (synchronous, active low): both FIFOs empty, all processes running, mailboxes free.
`default_nettype none

module two_level_ready_queue_scheduler (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  i_command,
    input  wire logic [7:0]  i_process_id,
    input  wire logic [7:0]  i_sender_id,
    input  wire logic [7:0]  i_message_length,
    output logic             o_done,
    output logic [7:0]       o_chosen_id,
    output logic [2:0]       o_status,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic       r_busy;
    logic       accept;
    logic [7:0] r_root_id;
    logic [2:0] r_cmd;
    logic [7:0] r_pid;
    logic [7:0] r_sender;
    logic [7:0] r_len;
    logic       r_done,   n_done;
    logic [7:0] r_chosen, n_chosen;
    logic [2:0] r_status, n_status;
    logic       pid_ok;
    logic [7:0] popped;

    tlrq_pkg::t_fifo_ctl  hi_ctl, lo_ctl;
    tlrq_pkg::t_fifo_sts  hi_sts, lo_sts;
    logic [7:0]           hi_head, lo_head;
    tlrq_pkg::t_tab_wr    tab_wr;
    tlrq_pkg::t_tab_entry tab_rd;
    logic                 tab_box_busy;

    assign accept = start && !r_busy;
    assign busy   = r_busy;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == tlrq_pkg::REG_ROOT_ID) ? {24'd0, r_root_id} : 32'd0;
    assign pid_ok = ({1'b0, r_pid} < tlrq_pkg::PID_LIMIT);

    tlrq_fifo u_hi_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_req  (accept),
        .i_ctl     (hi_ctl),
        .o_head_id (hi_head),
        .o_sts     (hi_sts)
    );

    tlrq_fifo u_lo_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_req  (accept),
        .i_ctl     (lo_ctl),
        .o_head_id (lo_head),
        .o_sts     (lo_sts)
    );

    tlrq_ptab u_ptab (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_rd_req      (accept),
        .i_rd_idx      (i_process_id[tlrq_pkg::PID_W-1:0]),
        .i_wr          (tab_wr),
        .o_rd_entry    (tab_rd),
        .o_rd_box_busy (tab_box_busy)
    );

    always_comb begin
        hi_ctl       = '0;
        lo_ctl       = '0;
        hi_ctl.id    = r_pid;
        lo_ctl.id    = r_pid;
        tab_wr       = '0;
        tab_wr.idx   = r_pid[tlrq_pkg::PID_W-1:0];
        tab_wr.entry = tab_rd;
        popped       = lo_head;
        n_done       = r_busy;
        n_chosen     = r_pid;
        n_status     = tlrq_pkg::ST_OK;
        if (r_busy) begin
            unique case (r_cmd)
                tlrq_pkg::CMD_SCHEDULE: begin
                    priority if (!hi_sts.empty) begin
                        hi_ctl.pop = 1'b1;
                        popped     = hi_head;
                    end else if (!lo_sts.empty) begin
                        lo_ctl.pop = 1'b1;
                        popped     = lo_head;
                    end else begin
                        n_chosen = r_root_id;
                        n_status = tlrq_pkg::ST_EMPTY_ROOT;
                    end
                    if (!hi_sts.empty || !lo_sts.empty) begin
                        if (popped == 8'd0 || {1'b0, popped} >= tlrq_pkg::PID_LIMIT) begin
                            n_chosen = r_root_id;
                            n_status = tlrq_pkg::ST_INVALID_ROOT;
                        end else begin
                            n_chosen = popped;
                        end
                    end
                end
                tlrq_pkg::CMD_WAKE: begin
                    priority if (!pid_ok) begin
                        n_status = tlrq_pkg::ST_BAD_ID;
                    end else if (lo_sts.full) begin
                        n_status = tlrq_pkg::ST_FULL_DROP;
                    end else begin
                        lo_ctl.push = 1'b1;
                    end
                end
                tlrq_pkg::CMD_DORMANT, tlrq_pkg::CMD_STOP, tlrq_pkg::CMD_ZOMBIE: begin
                    if (!pid_ok) begin
                        n_status = tlrq_pkg::ST_BAD_ID;
                    end else begin
                        tab_wr.en          = 1'b1;
                        tab_wr.entry.state = 2'(r_cmd - 3'd1);
                    end
                end
                tlrq_pkg::CMD_SEND: begin
                    priority if (!pid_ok) begin
                        n_status = tlrq_pkg::ST_BAD_ID;
                    end else if (tab_box_busy) begin
                        n_status = tlrq_pkg::ST_BOX_BUSY;
                    end else if (r_len > tlrq_pkg::LEN_LIMIT) begin
                        n_status = tlrq_pkg::ST_TOO_LONG;
                    end else begin
                        tab_wr.en           = 1'b1;
                        tab_wr.set_busy     = 1'b1;
                        tab_wr.entry.sender = r_sender;
                        tab_wr.entry.length = r_len[6:0];
                        lo_ctl.pop          = !lo_sts.empty;
                        if (hi_sts.full) begin
                            n_status = tlrq_pkg::ST_FULL_DROP;
                        end else begin
                            hi_ctl.push = 1'b1;
                        end
                    end
                end
                default: begin
                    n_status = tlrq_pkg::ST_BAD_ID;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_done    <= 1'b0;
            r_root_id <= 8'd0;
        end else begin
            r_busy <= accept;
            r_done <= n_done;
            if (psel && penable && pwrite && paddr[2] == tlrq_pkg::REG_ROOT_ID) begin
                r_root_id <= pwdata[7:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd    <= i_command;
            r_pid    <= i_process_id;
            r_sender <= i_sender_id;
            r_len    <= i_message_length;
        end
        r_chosen <= n_chosen;
        r_status <= n_status;
    end

    assign o_done      = r_done;
    assign o_chosen_id = r_chosen;
    assign o_status    = r_status;

    a_busy_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |=> !r_busy)
        else $error("busy held beyond one cycle");

    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> ##1 r_done)
        else $error("accepted word produced no result");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("result without a command");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!hi_ctl.pop || !hi_sts.empty) && (!lo_ctl.pop || !lo_sts.empty))
        else $error("pop from an empty queue");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!hi_ctl.push || !hi_sts.full) && (!lo_ctl.push || !lo_sts.full))
        else $error("push into a full queue");

endmodule

`default_nettype wire

// ----- verif/tb_two_level_ready_queue_scheduler.sv -----
`timescale 1ns / 100ps

module tb_two_level_ready_queue_scheduler;

    import tlrq_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 4;
    localparam logic [2:0] ROOT_ADDR = {REG_ROOT_ID, 2'b00};

    typedef struct packed {
        logic [7:0] chosen_id;
        logic [2:0] status;
    } result_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  i_command;
    logic [7:0]  i_process_id;
    logic [7:0]  i_sender_id;
    logic [7:0]  i_message_length;
    logic        o_done;
    logic [7:0]  o_chosen_id;
    logic [2:0]  o_status;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    two_level_ready_queue_scheduler u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_command        (i_command),
        .i_process_id     (i_process_id),
        .i_sender_id      (i_sender_id),
        .i_message_length (i_message_length),
        .o_done           (o_done),
        .o_chosen_id      (o_chosen_id),
        .o_status         (o_status),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    logic [7:0] root_id;
    logic [7:0] hi_ids[$];
    logic [7:0] lo_ids[$];
    logic [1:0] proc_state[MAX_PROCESSES];
    bit         box_busy[MAX_PROCESSES];
    logic [7:0] box_sender[MAX_PROCESSES];
    logic [6:0] box_length[MAX_PROCESSES];

    result_t expected_results[$];
    result_t want_res;

    int errors;
    int words_sent;
    int root_writes;
    int status_seen[7];
    int no_gap_left;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("two_level_ready_queue_scheduler: mismatch");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("ERROR %s: got %0d, want %0d", what, got, want);
        errors++;
    endtask

    function automatic result_t predict_command(input logic [2:0] cmd, input logic [7:0] pid,
            input logic [7:0] snd, input logic [7:0] len);
        result_t r;
        logic [7:0] id;
        bit known;
        r.chosen_id = pid;
        r.status = ST_OK;
        known = (pid < MAX_PROCESSES);
        case (cmd)
            CMD_SCHEDULE: begin
                if (hi_ids.size() != 0) begin
                    id = hi_ids.pop_front();
                end else if (lo_ids.size() != 0) begin
                    id = lo_ids.pop_front();
                end else begin
                    r.chosen_id = root_id;
                    r.status = ST_EMPTY_ROOT;
                    return r;
                end
                if (id == 8'd0 || id >= MAX_PROCESSES) begin
                    r.chosen_id = root_id;
                    r.status = ST_INVALID_ROOT;
                end else begin
                    r.chosen_id = id;
                end
            end
            CMD_WAKE: begin
                if (!known) begin
                    r.status = ST_BAD_ID;
                end else if (lo_ids.size() >= QUEUE_DEPTH) begin
                    r.status = ST_FULL_DROP;
                end else begin
                    lo_ids.push_back(pid);
                end
            end
            CMD_DORMANT, CMD_STOP, CMD_ZOMBIE: begin
                if (!known) begin
                    r.status = ST_BAD_ID;
                end else begin
                    proc_state[pid] = 2'(cmd - 3'd1);
                end
            end
            CMD_SEND: begin
                if (!known) begin
                    r.status = ST_BAD_ID;
                end else if (box_busy[pid]) begin
                    r.status = ST_BOX_BUSY;
                end else if (len > MESSAGE_LIMIT) begin
                    r.status = ST_TOO_LONG;
                end else begin
                    box_busy[pid] = 1'b1;
                    box_sender[pid] = snd;
                    box_length[pid] = len[6:0];
                    if (lo_ids.size() != 0) begin
                        void'(lo_ids.pop_front());
                    end
                    if (hi_ids.size() >= QUEUE_DEPTH) begin
                        r.status = ST_FULL_DROP;
                    end else begin
                        hi_ids.push_back(pid);
                    end
                end
            end
            default: begin
                r.status = ST_BAD_ID;
            end
        endcase
        return r;
    endfunction

    task automatic issue_command(input logic [2:0] cmd, input logic [7:0] pid,
            input logic [7:0] snd, input logic [7:0] len);
        int gap;
        if (no_gap_left > 0) begin
            no_gap_left--;
            gap = 0;
        end else begin
            if ($urandom_range(0, 19) == 0) begin
                no_gap_left = $urandom_range(10, 40);
            end
            gap = $urandom_range(0, 15);
        end
        repeat (gap) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
        @(negedge i_clk);
        start <= 1'b1;
        i_command <= cmd;
        i_process_id <= pid;
        i_sender_id <= snd;
        i_message_length <= len;
        do @(posedge i_clk); while (busy);
        expected_results.push_back(predict_command(cmd, pid, snd, len));
        words_sent++;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        start <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_root(input logic [7:0] value);
        wait_drained();
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ROOT_ADDR;
        pwdata <= {24'd0, value};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        root_id = value;
        root_writes++;
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        pwdata <= 32'd0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[7:0] !== root_id) begin
            report_mismatch("root_id readback", prdata[7:0], root_id);
        end
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic drain_queues();
        while (hi_ids.size() != 0 || lo_ids.size() != 0) begin
            issue_command(CMD_SCHEDULE, 8'($urandom), 8'($urandom), 8'($urandom));
        end
    endtask

    task automatic test_empty_root();
        issue_command(CMD_SCHEDULE, 8'd0, 8'd0, 8'd0);
        write_root(8'd255);
        issue_command(CMD_SCHEDULE, 8'd255, 8'd255, 8'd255);
    endtask

    task automatic test_wake_extremes();
        issue_command(CMD_WAKE, 8'd0, 8'd0, 8'd0);
        issue_command(CMD_WAKE, 8'(MAX_PROCESSES - 1), 8'd0, 8'd0);
        issue_command(CMD_WAKE, 8'(MAX_PROCESSES), 8'd0, 8'd0);
        issue_command(CMD_WAKE, 8'd255, 8'd0, 8'd0);
        issue_command(CMD_SCHEDULE, 8'd0, 8'd0, 8'd0);
        issue_command(CMD_SCHEDULE, 8'd0, 8'd0, 8'd0);
        issue_command(CMD_SCHEDULE, 8'd0, 8'd0, 8'd0);
    endtask

    task automatic test_state_commands();
        issue_command(CMD_DORMANT, 8'd0, 8'd0, 8'd0);
        issue_command(CMD_STOP, 8'(MAX_PROCESSES - 1), 8'd0, 8'd0);
        issue_command(CMD_ZOMBIE, 8'd17, 8'd0, 8'd0);
        issue_command(CMD_DORMANT, 8'(MAX_PROCESSES), 8'd0, 8'd0);
        issue_command(CMD_ZOMBIE, 8'd255, 8'd0, 8'd0);
        issue_command(3'd6, 8'd255, 8'd255, 8'd255);
        issue_command(3'd7, 8'd1, 8'd0, 8'd0);
    endtask

    task automatic test_send_cases();
        issue_command(CMD_SEND, 8'd3, 8'd255, 8'(MESSAGE_LIMIT));
        issue_command(CMD_SEND, 8'd3, 8'd1, 8'd200);
        issue_command(CMD_SEND, 8'd4, 8'd2, 8'(MESSAGE_LIMIT + 1));
        issue_command(CMD_SEND, 8'd4, 8'd2, 8'd255);
        issue_command(CMD_SEND, 8'd255, 8'd2, 8'd0);
        issue_command(CMD_WAKE, 8'd9, 8'd0, 8'd0);
        issue_command(CMD_SEND, 8'd4, 8'd0, 8'd0);
        drain_queues();
        issue_command(CMD_SCHEDULE, 8'd0, 8'd0, 8'd0);
    endtask

    task automatic test_low_fifo_full();
        int n;
        drain_queues();
        n = QUEUE_DEPTH + $urandom_range(1, 4);
        repeat (n) begin
            issue_command(CMD_WAKE, ($urandom_range(0, 7) == 0) ? 8'd0 :
                8'($urandom_range(0, MAX_PROCESSES - 1)), 8'($urandom), 8'($urandom));
        end
        drain_queues();
        issue_command(CMD_SCHEDULE, 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic test_high_fifo_full();
        logic [7:0] free_boxes[$];
        int k;
        drain_queues();
        for (int p = 0; p < MAX_PROCESSES; p++) begin
            if (!box_busy[p]) begin
                free_boxes.push_back(8'(p));
            end
        end
        repeat (5) begin
            issue_command(CMD_WAKE, 8'($urandom_range(1, MAX_PROCESSES - 1)), 8'd0, 8'd0);
        end
        repeat (QUEUE_DEPTH + 1) begin
            if (free_boxes.size() != 0) begin
                k = $urandom_range(0, free_boxes.size() - 1);
                issue_command(CMD_SEND, free_boxes[k], 8'($urandom),
                    8'($urandom_range(0, MESSAGE_LIMIT)));
                free_boxes.delete(k);
            end
        end
        drain_queues();
    endtask

    task automatic test_random_mix(input int n);
        int r;
        logic [7:0] pid;
        logic [7:0] len;
        repeat (n) begin
            r = $urandom_range(0, 99);
            pid = ($urandom_range(0, 6) != 0) ? 8'($urandom_range(0, MAX_PROCESSES - 1)) :
                8'($urandom);
            len = ($urandom_range(0, 4) < 3) ? 8'($urandom_range(0, MESSAGE_LIMIT)) :
                8'($urandom);
            if (r < 30) begin
                issue_command(CMD_SCHEDULE, 8'($urandom), 8'($urandom), 8'($urandom));
            end else if (r < 60) begin
                issue_command(CMD_WAKE, pid, 8'($urandom), 8'($urandom));
            end else if (r < 75) begin
                issue_command(3'($urandom_range(CMD_DORMANT, CMD_ZOMBIE)), pid,
                    8'($urandom), 8'($urandom));
            end else if (r < 88) begin
                issue_command(CMD_SEND, pid, 8'($urandom), len);
            end else if (r < 94) begin
                issue_command(3'($urandom_range(6, 7)), 8'($urandom), 8'($urandom),
                    8'($urandom));
            end else begin
                issue_command(3'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result word, chosen_id", o_chosen_id, 0);
            end else begin
                want_res = expected_results.pop_front();
                if (o_chosen_id !== want_res.chosen_id) begin
                    report_mismatch("chosen_id", o_chosen_id, want_res.chosen_id);
                end
                if (o_status !== want_res.status) begin
                    report_mismatch("status", o_status, want_res.status);
                end
                if (want_res.status < 3'd7) begin
                    status_seen[want_res.status]++;
                end
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        start = 1'b0;
        i_command = CMD_SCHEDULE;
        i_process_id = 8'd0;
        i_sender_id = 8'd0;
        i_message_length = 8'd0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = 3'd0;
        pwdata = 32'd0;
        errors = 0;
        words_sent = 0;
        root_writes = 0;
        no_gap_left = 0;
        root_id = 8'd0;
        for (int p = 0; p < MAX_PROCESSES; p++) begin
            proc_state[p] = 2'd0;
            box_busy[p] = 1'b0;
            box_sender[p] = 8'd0;
            box_length[p] = 7'd0;
        end
        for (int s = 0; s < 7; s++) begin
            status_seen[s] = 0;
        end
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_root();
        test_wake_extremes();
        test_state_commands();
        test_send_cases();
        write_root(8'($urandom));
        test_low_fifo_full();
        test_high_fifo_full();
        test_random_mix(450);
        write_root(8'd0);
        test_low_fifo_full();
        test_random_mix(450);
        write_root(8'd255);
        test_random_mix(450);
        write_root(8'($urandom));
        test_random_mix(450);
        wait_drained();

        $display("%0d command words sent across %0d root_id settings", words_sent, root_writes);
        $display("statuses: ok %0d empty %0d invalid %0d full %0d busy %0d long %0d bad %0d",
            status_seen[0], status_seen[1], status_seen[2], status_seen[3],
            status_seen[4], status_seen[5], status_seen[6]);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("two_level_ready_queue_scheduler: match");
        end else begin
            $display("two_level_ready_queue_scheduler: mismatch");
        end
        $finish;
    end

endmodule
